// ===== sv/lpd_pkg.sv =====
package lpd_pkg;

    localparam int FRAC_BITS = 30;
    localparam int MAX_ORDER = 63;
    localparam int X_W       = 32;
    localparam int P_W       = 32;
    localparam int DP_W      = 44;
    localparam int DEG_W     = 6;
    localparam int DP_LO_W   = 22;
    localparam int RECIP_W   = 31;
    localparam int WIDE_W    = 80;

    localparam logic signed [P_W-1:0]  ONE_Q     = P_W'(longint'(1) << FRAC_BITS);
    localparam logic signed [P_W-1:0]  NEG_ONE_Q = -ONE_Q;
    localparam logic signed [DP_W-1:0] DP_LIM    = DP_W'(longint'(1) << (FRAC_BITS + 12));

    localparam logic signed [WIDE_W-1:0] HALF_Q    = WIDE_W'(longint'(1) << (FRAC_BITS - 1));
    localparam logic signed [WIDE_W-1:0] HALF_Q_M1 = HALF_Q - WIDE_W'(1);

    typedef logic [RECIP_W-1:0] t_recip;

    // round(2^30 / k); entry 0 held at 1.0
    localparam t_recip RECIP_ROM [0:(1 << DEG_W)-1] = '{
        31'd1073741824, 31'd1073741824, 31'd536870912,  31'd357913941,
        31'd268435456,  31'd214748365,  31'd178956971,  31'd153391689,
        31'd134217728,  31'd119304647,  31'd107374182,  31'd97612893,
        31'd89478485,   31'd82595525,   31'd76695845,   31'd71582788,
        31'd67108864,   31'd63161284,   31'd59652324,   31'd56512728,
        31'd53687091,   31'd51130563,   31'd48806447,   31'd46684427,
        31'd44739243,   31'd42949673,   31'd41297762,   31'd39768216,
        31'd38347922,   31'd37025580,   31'd35791394,   31'd34636833,
        31'd33554432,   31'd32537631,   31'd31580642,   31'd30678338,
        31'd29826162,   31'd29020049,   31'd28256364,   31'd27531842,
        31'd26843546,   31'd26188825,   31'd25565282,   31'd24970740,
        31'd24403223,   31'd23860929,   31'd23342214,   31'd22845571,
        31'd22369621,   31'd21913098,   31'd21474836,   31'd21053761,
        31'd20648881,   31'd20259280,   31'd19884108,   31'd19522579,
        31'd19173961,   31'd18837576,   31'd18512790,   31'd18199014,
        31'd17895697,   31'd17602325,   31'd17318417,   31'd17043521
    };

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_PH_A,
        S_PH_B,
        S_PH_C,
        S_PH_D
    } t_state;

    typedef struct packed {
        logic load_x;
        logic emit0;
        logic ph_a;
        logic ph_b;
        logic ph_c;
        logic ph_d;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic cur_last;
        logic next_last;
    } t_sts;

    // drop FRAC_BITS, nearest, ties away from zero; neg is the sign of v
    function automatic logic signed [WIDE_W-1:0] round_q(
        input logic signed [WIDE_W-1:0] v,
        input logic                     neg
    );
        logic signed [WIDE_W-1:0] bias;
        bias = neg ? HALF_Q_M1 : HALF_Q;
        return (v + bias) >>> FRAC_BITS;
    endfunction

endpackage

// ===== sv/lpd_in_if.sv =====
interface lpd_in_if;
    import lpd_pkg::*;

    logic                  valid;
    logic                  ready;
    logic signed [X_W-1:0] x;

    modport source (output valid, output x, input ready);
    modport sink   (input valid, input x, output ready);
endinterface

// ===== sv/lpd_out_if.sv =====
interface lpd_out_if;
    import lpd_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [DEG_W-1:0]       degree;
    logic signed [P_W-1:0]  p_value;
    logic signed [DP_W-1:0] dp_value;
    logic                   last;

    modport source (output valid, output degree, output p_value, output dp_value,
                    output last, input ready);
    modport sink   (input valid, input degree, input p_value, input dp_value,
                    input last, output ready);
endinterface

// ===== sv/legendre_poly_with_derivative_top.sv =====
// Legendre polynomials P_n(x) and dP_n/dx for n = 0 .. max_order.
//
// Input channel i_in: one beat carries a point x, signed Q1.30; values beyond
// +-1.0 are clamped. Output channel o_out: one beat per degree, in rising
// order, carrying degree, p_value (Q1.30) and dp_value (Q13.30), both
// saturated; last marks the beat for degree max_order.
// Config: i_cfg_wr_en / i_cfg_wr_data write max_order (0..63); write it only
// while no point is in flight.
//
// Timing: the point is first registered, then the first beat (degree 0) is
// loaded into the output register. Each further degree passes through the
// shared recurrence datapath in phases A, B, C and D; a new point is taken
// once the last beat of the previous one sits in the output register.
// The output register holds its beat while the receiver stalls; the
// sequencer waits with the next degree until that register frees up.
// Reset (synchronous, active low) clears max_order to 0 and drops any beat
// in flight.
module legendre_poly_with_derivative_top (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  logic [lpd_pkg::DEG_W-1:0] i_cfg_wr_data,
    lpd_in_if.sink                    i_in,
    lpd_out_if.source                 o_out
);
    import lpd_pkg::*;

    t_cmd cmd;
    t_sts sts;

    lpd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    lpd_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_x           (i_in.x),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_out_valid   (o_out.valid),
        .i_out_ready   (o_out.ready),
        .o_degree      (o_out.degree),
        .o_p_value     (o_out.p_value),
        .o_dp_value    (o_out.dp_value),
        .o_last        (o_out.last)
    );

endmodule

// ===== sv/lpd_ctrl.sv =====
module lpd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  lpd_pkg::t_sts i_sts,
    output lpd_pkg::t_cmd o_cmd
);
    import lpd_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_INIT;
            end
            S_INIT: begin
                if (i_sts.out_free) n_state = i_sts.cur_last ? S_IDLE : S_PH_A;
            end
            S_PH_A: n_state = S_PH_B;
            S_PH_B: n_state = S_PH_C;
            S_PH_C: n_state = S_PH_D;
            S_PH_D: begin
                if (i_sts.out_free) n_state = i_sts.next_last ? S_IDLE : S_PH_A;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.load_x = i_in_valid;
            end
            S_INIT: o_cmd.emit0 = i_sts.out_free;
            S_PH_A: o_cmd.ph_a  = 1'b1;
            S_PH_B: o_cmd.ph_b  = 1'b1;
            S_PH_C: o_cmd.ph_c  = 1'b1;
            S_PH_D: o_cmd.ph_d  = i_sts.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

// ===== sv/lpd_datapath.sv =====
module lpd_datapath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [lpd_pkg::DEG_W-1:0]      i_cfg_wr_data,
    input  logic signed [lpd_pkg::X_W-1:0] i_x,
    input  lpd_pkg::t_cmd                  i_cmd,
    output lpd_pkg::t_sts                  o_sts,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [lpd_pkg::DEG_W-1:0]      o_degree,
    output logic signed [lpd_pkg::P_W-1:0] o_p_value,
    output logic signed [lpd_pkg::DP_W-1:0] o_dp_value,
    output logic                           o_last
);
    import lpd_pkg::*;

    logic [DEG_W-1:0]       r_max_order;
    logic                   r_out_valid;

    logic signed [X_W-1:0]  r_x;
    logic signed [P_W-1:0]  r_p_prev;
    logic signed [P_W-1:0]  r_p_cur;
    logic signed [DP_W-1:0] r_dp;
    logic [DEG_W-1:0]       r_n;

    logic signed [63:0]     r_pt;
    logic signed [54:0]     r_pdl;
    logic signed [38:0]     r_np;
    t_recip                 r_recip;
    logic signed [33:0]     r_a;
    logic signed [32:0]     r_b;
    logic signed [53:0]     r_pdh;
    logic signed [64:0]     r_pr;
    logic signed [45:0]     r_rdp;

    logic [DEG_W-1:0]       r_deg_out;
    logic signed [P_W-1:0]  r_p_out;
    logic signed [DP_W-1:0] r_dp_out;
    logic                   r_last_out;

    logic [DEG_W-1:0]       k;
    logic signed [X_W-1:0]  x_clamp;
    logic signed [33:0]     t_rnd;
    logic signed [WIDE_W-1:0] dp_sum;
    logic signed [45:0]     dp_rnd;
    logic signed [32:0]     m_rnd;
    logic signed [34:0]     p_raw;
    logic signed [46:0]     d_raw;
    logic signed [P_W-1:0]  n_p_cur;
    logic signed [DP_W-1:0] n_dp;

    assign k = r_n + DEG_W'(1);

    always_comb begin
        if (i_x > ONE_Q) begin
            x_clamp = ONE_Q;
        end else if (i_x < NEG_ONE_Q) begin
            x_clamp = NEG_ONE_Q;
        end else begin
            x_clamp = i_x;
        end
    end

    assign t_rnd  = 34'(round_q(WIDE_W'(r_pt), r_pt[63]));
    // x * dP rebuilt from its two partial products; sign known from the operands
    assign dp_sum = (WIDE_W'(r_pdh) <<< DP_LO_W) + WIDE_W'(r_pdl);
    assign dp_rnd = 46'(round_q(dp_sum, r_x[X_W-1] ^ r_dp[DP_W-1]));
    assign m_rnd  = 33'(round_q(WIDE_W'(r_pr), r_pr[64]));
    assign p_raw  = 35'(r_a) - 35'(m_rnd);
    assign d_raw  = 47'(r_np) + 47'(r_rdp);

    always_comb begin
        if (k == DEG_W'(1)) begin
            n_p_cur = r_x;
        end else if (p_raw > 35'(ONE_Q)) begin
            n_p_cur = ONE_Q;
        end else if (p_raw < 35'(NEG_ONE_Q)) begin
            n_p_cur = NEG_ONE_Q;
        end else begin
            n_p_cur = P_W'(p_raw);
        end
    end

    always_comb begin
        if (d_raw > 47'(DP_LIM)) begin
            n_dp = DP_LIM;
        end else if (d_raw < -47'(DP_LIM)) begin
            n_dp = -DP_LIM;
        end else begin
            n_dp = DP_W'(d_raw);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_order <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) r_max_order <= i_cfg_wr_data;
            if (i_cmd.emit0 || i_cmd.ph_d) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_x) begin
            r_x      <= x_clamp;
            r_p_prev <= '0;
            r_p_cur  <= ONE_Q;
            r_dp     <= '0;
            r_n      <= '0;
        end
        if (i_cmd.ph_a) begin
            r_pt    <= r_x * r_p_cur;
            r_pdl   <= r_x * $signed({1'b0, r_dp[DP_LO_W-1:0]});
            r_np    <= $signed({1'b0, k}) * r_p_cur;
            r_recip <= RECIP_ROM[k];
        end
        if (i_cmd.ph_b) begin
            r_a   <= (t_rnd <<< 1) - 34'(r_p_prev);
            r_b   <= 33'(t_rnd) - 33'(r_p_prev);
            r_pdh <= r_x * $signed(r_dp[DP_W-1:DP_LO_W]);
        end
        if (i_cmd.ph_c) begin
            r_pr  <= r_b * $signed({1'b0, r_recip});
            r_rdp <= dp_rnd;
        end
        if (i_cmd.ph_d) begin
            r_p_prev <= r_p_cur;
            r_p_cur  <= n_p_cur;
            r_dp     <= n_dp;
            r_n      <= k;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit0) begin
            r_deg_out  <= '0;
            r_p_out    <= ONE_Q;
            r_dp_out   <= '0;
            r_last_out <= o_sts.cur_last;
        end else if (i_cmd.ph_d) begin
            r_deg_out  <= k;
            r_p_out    <= n_p_cur;
            r_dp_out   <= n_dp;
            r_last_out <= o_sts.next_last;
        end
    end

    assign o_sts.out_free  = !r_out_valid || i_out_ready;
    assign o_sts.cur_last  = (r_n == r_max_order);
    assign o_sts.next_last = (k == r_max_order);

    assign o_out_valid = r_out_valid;
    assign o_degree    = r_deg_out;
    assign o_p_value   = r_p_out;
    assign o_dp_value  = r_dp_out;
    assign o_last      = r_last_out;

endmodule

// ===== test/tb_legendre_poly_with_derivative_top.sv =====
module tb_legendre_poly_with_derivative_top;
    import lpd_pkg::*;

    localparam longint Q_ONE       = longint'(1) << FRAC_BITS;
    localparam longint DP_CEIL     = longint'(1) << (FRAC_BITS + 12);
    localparam int     STALL_LIMIT = 4000;
    localparam int     PHASES      = 10;
    localparam int     PHASE_PTS   = 34;

    typedef struct {
        logic [DEG_W-1:0]       degree;
        logic signed [P_W-1:0]  p_value;
        logic signed [DP_W-1:0] dp_value;
        logic                   last;
    } t_lp_term;

    class legendre_board;
        t_lp_term         terms_due[$];
        logic [DEG_W-1:0] order;
        int               mismatches;

        function new();
            order      = '0;
            mismatches = 0;
        endfunction

        static function longint limit(longint v, longint lim);
            if (v > lim) return lim;
            if (v < -lim) return -lim;
            return v;
        endfunction

        // exact product, drop FRAC_BITS rounding half away from zero
        static function longint q_mul(longint a, longint b);
            logic [63:0]  ua;
            logic [63:0]  ub;
            logic [127:0] prod;
            logic         neg;
            neg  = (a < 0) != (b < 0);
            ua   = (a < 0) ? 64'(-a) : 64'(a);
            ub   = (b < 0) ? 64'(-b) : 64'(b);
            prod = {64'd0, ua} * {64'd0, ub};
            prod = (prod + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
            if (prod > {64'd0, 64'h7FFF_FFFF_FFFF_FFFF})
                prod = {64'd0, 64'h7FFF_FFFF_FFFF_FFFF};
            return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
        endfunction

        function void add_point(logic signed [X_W-1:0] x);
            longint   xv, p_prev, p_cur, dp, t, a, b, p_new, rcp;
            int       top;
            t_lp_term term;
            xv     = limit(longint'(x), Q_ONE);
            top    = (int'(order) > MAX_ORDER) ? MAX_ORDER : int'(order);
            p_prev = 0;
            p_cur  = Q_ONE;
            dp     = 0;
            for (int n = 0; n <= top; n++) begin
                if (n >= 1) begin
                    if (n == 1) begin
                        p_new = xv;
                    end else begin
                        t     = q_mul(xv, p_cur);
                        a     = 2 * t - p_prev;
                        b     = t - p_prev;
                        rcp   = (Q_ONE + n / 2) / n;
                        p_new = limit(a - q_mul(b, rcp), Q_ONE);
                    end
                    dp     = limit(longint'(n) * p_cur + q_mul(xv, dp), DP_CEIL);
                    p_prev = p_cur;
                    p_cur  = p_new;
                end
                term.degree   = n[DEG_W-1:0];
                term.p_value  = p_cur[P_W-1:0];
                term.dp_value = dp[DP_W-1:0];
                term.last     = (n == top);
                terms_due.push_back(term);
            end
        endfunction

        function void check_term(logic [DEG_W-1:0] degree, logic signed [P_W-1:0] p,
                                 logic signed [DP_W-1:0] dp, logic last);
            t_lp_term e;
            if (terms_due.size() == 0) begin
                $error("unexpected beat: degree %0d p_value %0d", degree, p);
                mismatches++;
                return;
            end
            e = terms_due.pop_front();
            if (degree !== e.degree) begin
                $error("degree: expected %0d, got %0d", e.degree, degree);
                mismatches++;
            end
            if (p !== e.p_value) begin
                $error("p_value: expected %0d, got %0d", e.p_value, p);
                mismatches++;
            end
            if (dp !== e.dp_value) begin
                $error("dp_value: expected %0d, got %0d", e.dp_value, dp);
                mismatches++;
            end
            if (last !== e.last) begin
                $error("last: expected %0d, got %0d", e.last, last);
                mismatches++;
            end
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_wr_en;
    logic [DEG_W-1:0] i_cfg_wr_data;

    lpd_in_if  in_ch ();
    lpd_out_if out_ch ();

    legendre_poly_with_derivative_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in          (in_ch),
        .o_out         (out_ch)
    );

    legendre_board board = new();
    int            burst_left = 0;
    int            idle_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // beat monitor and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready)
                board.add_point(in_ch.x);
            if (out_ch.valid && out_ch.ready)
                board.check_term(out_ch.degree, out_ch.p_value, out_ch.dp_value,
                                 out_ch.last);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // receiver back-pressure: free-flowing, random, or a periodic stall pattern
    initial begin
        int mode, span, period, on_len;
        out_ch.ready = 1'b0;
        forever begin
            mode   = $urandom_range(0, 2);
            span   = $urandom_range(32, 200);
            period = $urandom_range(2, 12);
            on_len = $urandom_range(1, period);
            for (int c = 0; c < span; c++) begin
                @(negedge i_clk);
                case (mode)
                    0: begin
                        out_ch.ready <= 1'b1;
                    end
                    1: begin
                        out_ch.ready <= ($urandom_range(0, 3) != 0);
                    end
                    default: begin
                        out_ch.ready <= ((c % period) < on_len);
                    end
                endcase
            end
        end
    end

    task automatic send_point(input logic signed [X_W-1:0] v);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap != 0) begin
                @(negedge i_clk);
                in_ch.valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        @(negedge i_clk);
        in_ch.valid <= 1'b1;
        in_ch.x     <= v;
        do @(posedge i_clk); while (!in_ch.ready);
        burst_left--;
    endtask

    // drop valid and let every outstanding beat drain before touching max_order
    task automatic drain;
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        burst_left = 0;
        while (board.terms_due.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_order(input logic [DEG_W-1:0] v);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        board.order = v;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    function automatic logic signed [X_W-1:0] random_point();
        case ($urandom_range(0, 9))
            0, 1: return $urandom;
            2: begin
                case ($urandom_range(0, 2))
                    0: return Q_ONE[X_W-1:0];
                    1: return -Q_ONE[X_W-1:0];
                    default: return '0;
                endcase
            end
            default: return $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
        endcase
    endfunction

    initial begin
        logic signed [X_W-1:0] corner_pts[14];
        int                    phase_orders[6];
        corner_pts = '{32'sh4000_0000, -32'sh4000_0000, 32'sd0, 32'sd1, -32'sd1,
                       32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh4000_0001,
                       -32'sh4000_0001, 32'sh2000_0000, -32'sh2000_0000,
                       32'sh3FFF_FFFF, 32'shC000_0001, 32'sh5555_5555};
        phase_orders = '{1, 0, 2, 63, 3, 5};

        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        in_ch.valid   = 1'b0;
        in_ch.x       = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // max_order straight out of reset is 0; includes an over-range point
        send_point(32'sh4000_0000);
        send_point(-32'sh4000_0000);
        send_point(32'sd0);
        send_point(32'sh7FFF_FFFF);
        drain();
        write_order(6'd63);
        foreach (corner_pts[i])
            send_point(corner_pts[i]);

        for (int ph = 0; ph < PHASES; ph++) begin
            drain();
            write_order((ph < 6) ? DEG_W'(phase_orders[ph])
                                 : DEG_W'($urandom_range(0, 15)));
            repeat (PHASE_PTS) send_point(random_point());
        end

        drain();
        repeat (12) @(posedge i_clk);
        if (board.mismatches == 0 && board.terms_due.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
